// File: hdl/hsvrgb_pkg.sv
`default_nettype none

package hsvrgb_pkg;

  localparam int unsigned HUE_TURN     = 360;
  localparam int unsigned HUE_SECTOR   = 60;
  localparam int unsigned DIV_X        = 15300;
  localparam int unsigned RECIP_X      = 280716;
  localparam int unsigned RECIP_X_SHFT = 32;
  localparam int unsigned DIV_Y        = 255;
  localparam int unsigned RECIP_Y      = 65793;
  localparam int unsigned RECIP_Y_SHFT = 24;
  localparam int unsigned QW           = 9;

  typedef enum logic [2:0] {
    SEC_R_G = 3'd0,
    SEC_G_R = 3'd1,
    SEC_G_B = 3'd2,
    SEC_B_G = 3'd3,
    SEC_B_R = 3'd4,
    SEC_R_B = 3'd5
  } sector_t;

  typedef struct packed {
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
    logic [7:0] white_in;
    logic [7:0] alpha_in;
  } hsv_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white_out;
    logic [7:0] alpha_out;
  } rgb_word_t;

  typedef struct packed {
    sector_t     sector;
    logic [5:0]  j;
    logic [15:0] p;
    logic [7:0]  brightness;
    logic [7:0]  white;
    logic [7:0]  alpha;
  } st1_t;

  typedef struct packed {
    sector_t     sector;
    logic [21:0] x;
    logic [15:0] y;
    logic [7:0]  brightness;
    logic [7:0]  white;
    logic [7:0]  alpha;
  } st2_t;

  typedef struct packed {
    sector_t       sector;
    logic [21:0]   x;
    logic [15:0]   y;
    logic [QW-1:0] qx0;
    logic [QW-1:0] qy0;
    logic [7:0]    brightness;
    logic [7:0]    white;
    logic [7:0]    alpha;
  } st3_t;

  typedef struct packed {
    sector_t       sector;
    logic [QW-1:0] q_ramp;
    logic [QW-1:0] q_zero;
    logic [7:0]    brightness;
    logic [7:0]    white;
    logic [7:0]    alpha;
  } st4_t;

endpackage

`default_nettype wire

// File: hdl/hsvrgb_front.sv
`default_nettype none

module hsvrgb_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  valid,
  input  hsvrgb_pkg::hsv_word_t word,
  output logic                  st2_valid,
  output hsvrgb_pkg::st2_t      st2
);

  logic [8:0]          hm;
  logic [8:0]          sec_base;
  logic [5:0]          f;
  hsvrgb_pkg::sector_t sector;
  hsvrgb_pkg::st1_t    st1_next;
  hsvrgb_pkg::st1_t    st1;
  logic                st1_valid;
  hsvrgb_pkg::st2_t    st2_next;
  logic [21:0]         pj;

  // stage 1: wrap hue, find sector, chroma product
  always_comb begin
    hm = (word.hue >= 9'(hsvrgb_pkg::HUE_TURN)) ?
         word.hue - 9'(hsvrgb_pkg::HUE_TURN) : word.hue;
    if (hm >= 9'(5 * hsvrgb_pkg::HUE_SECTOR)) begin
      sector   = hsvrgb_pkg::SEC_R_B;
      sec_base = 9'(5 * hsvrgb_pkg::HUE_SECTOR);
    end else if (hm >= 9'(4 * hsvrgb_pkg::HUE_SECTOR)) begin
      sector   = hsvrgb_pkg::SEC_B_R;
      sec_base = 9'(4 * hsvrgb_pkg::HUE_SECTOR);
    end else if (hm >= 9'(3 * hsvrgb_pkg::HUE_SECTOR)) begin
      sector   = hsvrgb_pkg::SEC_B_G;
      sec_base = 9'(3 * hsvrgb_pkg::HUE_SECTOR);
    end else if (hm >= 9'(2 * hsvrgb_pkg::HUE_SECTOR)) begin
      sector   = hsvrgb_pkg::SEC_G_B;
      sec_base = 9'(2 * hsvrgb_pkg::HUE_SECTOR);
    end else if (hm >= 9'(hsvrgb_pkg::HUE_SECTOR)) begin
      sector   = hsvrgb_pkg::SEC_G_R;
      sec_base = 9'(hsvrgb_pkg::HUE_SECTOR);
    end else begin
      sector   = hsvrgb_pkg::SEC_R_G;
      sec_base = '0;
    end
    f = 6'(hm - sec_base);
    st1_next.sector     = sector;
    st1_next.j          = sector[0] ? f : 6'(hsvrgb_pkg::HUE_SECTOR) - f;
    st1_next.p          = {8'b0, word.saturation} * {8'b0, word.brightness};
    st1_next.brightness = word.brightness;
    st1_next.white      = word.white_in;
    st1_next.alpha      = word.alpha_in;
  end

  // stage 2: numerators for the two ceiling divisions
  always_comb begin
    pj                  = {6'b0, st1.p} * {16'b0, st1.j};
    st2_next.sector     = st1.sector;
    st2_next.x          = pj + 22'(hsvrgb_pkg::DIV_X - 1);
    st2_next.y          = st1.p + 16'(hsvrgb_pkg::DIV_Y - 1);
    st2_next.brightness = st1.brightness;
    st2_next.white      = st1.white;
    st2_next.alpha      = st1.alpha;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
      st2_valid <= 1'b0;
    end else if (en) begin
      st1_valid <= valid;
      st2_valid <= st1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1 <= st1_next;
      st2 <= st2_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/hsvrgb_div.sv
`default_nettype none

module hsvrgb_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             st2_valid,
  input  hsvrgb_pkg::st2_t st2,
  output logic             st4_valid,
  output hsvrgb_pkg::st4_t st4
);

  localparam int unsigned PXW = 22 + 19;
  localparam int unsigned PYW = 16 + 17;

  logic [PXW-1:0]            prod_x;
  logic [PYW-1:0]            prod_y;
  hsvrgb_pkg::st3_t          st3_next;
  hsvrgb_pkg::st3_t          st3;
  logic                      st3_valid;
  logic [21:0]               mul_x;
  logic [21:0]               rem_x;
  logic [15:0]               mul_y;
  logic [15:0]               rem_y;
  hsvrgb_pkg::st4_t          st4_next;

  // stage 3: reciprocal multiply, estimate low by at most one
  always_comb begin
    prod_x              = {19'b0, st2.x} * PXW'(hsvrgb_pkg::RECIP_X);
    prod_y              = {17'b0, st2.y} * PYW'(hsvrgb_pkg::RECIP_Y);
    st3_next.sector     = st2.sector;
    st3_next.x          = st2.x;
    st3_next.y          = st2.y;
    st3_next.qx0        = prod_x[hsvrgb_pkg::RECIP_X_SHFT +: hsvrgb_pkg::QW];
    st3_next.qy0        = prod_y[hsvrgb_pkg::RECIP_Y_SHFT +: hsvrgb_pkg::QW];
    st3_next.brightness = st2.brightness;
    st3_next.white      = st2.white;
    st3_next.alpha      = st2.alpha;
  end

  // stage 4: remainder check and correction
  always_comb begin
    mul_x = {13'b0, st3.qx0} * 22'(hsvrgb_pkg::DIV_X);
    rem_x = st3.x - mul_x;
    mul_y = {7'b0, st3.qy0} * 16'(hsvrgb_pkg::DIV_Y);
    rem_y = st3.y - mul_y;
    st4_next.sector     = st3.sector;
    st4_next.q_ramp     = (rem_x >= 22'(hsvrgb_pkg::DIV_X)) ? st3.qx0 + 1'b1 : st3.qx0;
    st4_next.q_zero     = (rem_y >= 16'(hsvrgb_pkg::DIV_Y)) ? st3.qy0 + 1'b1 : st3.qy0;
    st4_next.brightness = st3.brightness;
    st4_next.white      = st3.white;
    st4_next.alpha      = st3.alpha;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st3_valid <= 1'b0;
      st4_valid <= 1'b0;
    end else if (en) begin
      st3_valid <= st2_valid;
      st4_valid <= st3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st3 <= st3_next;
      st4 <= st4_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/hsvrgb_out.sv
`default_nettype none

module hsvrgb_out (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  st4_valid,
  input  hsvrgb_pkg::st4_t      st4,
  input  logic                  rgb_stall,
  output logic                  rgb_valid,
  output hsvrgb_pkg::rgb_word_t rgb,
  output logic                  full
);

  logic [8:0]            d_ramp;
  logic [8:0]            d_zero;
  logic [7:0]            full_ch;
  logic [7:0]            ramp_ch;
  logic [7:0]            zero_ch;
  hsvrgb_pkg::rgb_word_t word_new;
  hsvrgb_pkg::rgb_word_t skid;
  logic                  arrive;
  logic                  open;

  // channel select
  always_comb begin
    d_ramp  = {1'b0, st4.brightness} - st4.q_ramp;
    d_zero  = {1'b0, st4.brightness} - st4.q_zero;
    full_ch = st4.brightness;
    ramp_ch = d_ramp[7:0];
    zero_ch = d_zero[7:0];
    word_new.white_out = st4.white;
    word_new.alpha_out = st4.alpha;
    case (st4.sector)
      hsvrgb_pkg::SEC_R_G: begin
        word_new.red = full_ch; word_new.green = ramp_ch; word_new.blue = zero_ch;
      end
      hsvrgb_pkg::SEC_G_R: begin
        word_new.red = ramp_ch; word_new.green = full_ch; word_new.blue = zero_ch;
      end
      hsvrgb_pkg::SEC_G_B: begin
        word_new.red = zero_ch; word_new.green = full_ch; word_new.blue = ramp_ch;
      end
      hsvrgb_pkg::SEC_B_G: begin
        word_new.red = zero_ch; word_new.green = ramp_ch; word_new.blue = full_ch;
      end
      hsvrgb_pkg::SEC_B_R: begin
        word_new.red = ramp_ch; word_new.green = zero_ch; word_new.blue = full_ch;
      end
      default: begin
        word_new.red = full_ch; word_new.green = zero_ch; word_new.blue = ramp_ch;
      end
    endcase
  end

  assign arrive = st4_valid & ~full;
  assign open   = ~rgb_valid | ~rgb_stall;

  // output register plus skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      rgb_valid <= 1'b0;
      full      <= 1'b0;
    end else if (open) begin
      rgb_valid <= full | arrive;
      full      <= 1'b0;
    end else if (arrive) begin
      full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (open) begin
      rgb <= full ? skid : word_new;
    end
    if (!open && arrive) begin
      skid <= word_new;
    end
  end

endmodule

`default_nettype wire

// File: hdl/hsv_to_rgbwa_pixel.sv
// channel  | valid     | stall     | word
// ---------+-----------+-----------+------------------------
// hsv in   | hsv_valid | hsv_stall | hsv (hsv_word_t)
// rgb out  | rgb_valid | rgb_stall | rgb (rgb_word_t)
//
// one word per clock while hsv_stall is low; from accept to rgb_valid
// a word passes sector, numerator, multiply, correction and output registers
// rst clears all valid bits and the skid flag, payload is not reset
// hsv_stall is the registered skid flag, so no path from rgb_stall
// a stalled output parks one word in the skid and freezes the pipe
`default_nettype none

module hsv_to_rgbwa_pixel (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  hsv_valid,
  output logic                  hsv_stall,
  input  hsvrgb_pkg::hsv_word_t hsv,
  output logic                  rgb_valid,
  input  logic                  rgb_stall,
  output hsvrgb_pkg::rgb_word_t rgb
);

  logic             en;
  logic             full;
  logic             st2_valid;
  hsvrgb_pkg::st2_t st2;
  logic             st4_valid;
  hsvrgb_pkg::st4_t st4;

  assign en        = ~full;
  assign hsv_stall = full;

  hsvrgb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid     (hsv_valid),
    .word      (hsv),
    .st2_valid (st2_valid),
    .st2       (st2)
  );

  hsvrgb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .st2_valid (st2_valid),
    .st2       (st2),
    .st4_valid (st4_valid),
    .st4       (st4)
  );

  hsvrgb_out u_out (
    .clk       (clk),
    .rst       (rst),
    .st4_valid (st4_valid),
    .st4       (st4),
    .rgb_stall (rgb_stall),
    .rgb_valid (rgb_valid),
    .rgb       (rgb),
    .full      (full)
  );

`ifndef SYNTHESIS
  a_skid_has_out: assert property (@(posedge clk) disable iff (rst)
    full |-> rgb_valid)
    else $error("skid holds a word while output is empty");

  a_skid_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(rgb_valid && rgb_stall))
    else $error("skid filled without a stalled output");

  a_ramp_le_zero: assert property (@(posedge clk) disable iff (rst)
    st4_valid |-> (st4.q_ramp <= st4.q_zero))
    else $error("ramp quotient exceeds offset quotient");

  a_zero_le_v: assert property (@(posedge clk) disable iff (rst)
    st4_valid |-> (st4.q_zero <= {1'b0, st4.brightness}))
    else $error("chroma exceeds brightness");
`endif

endmodule

`default_nettype wire

// File: tb/tb_hsv_to_rgbwa_pixel.sv
`timescale 1ns / 1ps

module tb_hsv_to_rgbwa_pixel;

  localparam int unsigned RAND_PIXELS = 600;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned DRAIN_CLKS  = 20;
  localparam int unsigned FULL_TURN   = 360;
  localparam int unsigned SECTOR_DEG  = 60;
  localparam int unsigned DENOM       = 255 * 60;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  hsv_valid = 1'b0;
  logic                  hsv_stall;
  hsvrgb_pkg::hsv_word_t hsv = '0;
  logic                  rgb_valid;
  logic                  rgb_stall = 1'b0;
  hsvrgb_pkg::rgb_word_t rgb;

  hsvrgb_pkg::hsv_word_t pixel_q[$];
  hsvrgb_pkg::rgb_word_t rgb_due_q[$];
  hsvrgb_pkg::rgb_word_t want;
  int unsigned tx_gap, tx_quiet, rx_hold, rx_quiet, idle_clks;
  int unsigned n_err, n_checked, n_wrapped;

  hsv_to_rgbwa_pixel u_top (
    .clk       (clk),
    .rst       (rst),
    .hsv_valid (hsv_valid),
    .hsv_stall (hsv_stall),
    .hsv       (hsv),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .rgb       (rgb)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic hsvrgb_pkg::rgb_word_t convert_pixel(hsvrgb_pkg::hsv_word_t px);
    int unsigned           h, f, k, p, base, ramp, zero, v;
    hsvrgb_pkg::sector_t   sec;
    hsvrgb_pkg::rgb_word_t res;
    h    = px.hue % FULL_TURN;
    sec  = hsvrgb_pkg::sector_t'(h / SECTOR_DEG);
    f    = h % SECTOR_DEG;
    k    = (h / SECTOR_DEG) % 2 == 1 ? SECTOR_DEG - f : f;
    v    = px.brightness;
    p    = v * px.saturation;
    base = v * DENOM - p * SECTOR_DEG;
    ramp = (base + p * k) / DENOM;
    zero = base / DENOM;
    case (sec)
      hsvrgb_pkg::SEC_R_G: begin
        res.red = 8'(v);    res.green = 8'(ramp); res.blue = 8'(zero);
      end
      hsvrgb_pkg::SEC_G_R: begin
        res.red = 8'(ramp); res.green = 8'(v);    res.blue = 8'(zero);
      end
      hsvrgb_pkg::SEC_G_B: begin
        res.red = 8'(zero); res.green = 8'(v);    res.blue = 8'(ramp);
      end
      hsvrgb_pkg::SEC_B_G: begin
        res.red = 8'(zero); res.green = 8'(ramp); res.blue = 8'(v);
      end
      hsvrgb_pkg::SEC_B_R: begin
        res.red = 8'(ramp); res.green = 8'(zero); res.blue = 8'(v);
      end
      default: begin
        res.red = 8'(v);    res.green = 8'(zero); res.blue = 8'(ramp);
      end
    endcase
    res.white_out = px.white_in;
    res.alpha_out = px.alpha_in;
    return res;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [7:0] rand_level();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 8'd0;
    if (r < 20) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [8:0] rand_hue();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return 9'($urandom_range(0, FULL_TURN - 1));
    if (r < 85) return 9'((SECTOR_DEG * $urandom_range(1, 6) + $urandom_range(0, 2) - 1) % 512);
    return 9'($urandom_range(FULL_TURN, 511));
  endfunction

  task automatic add_pixel(input logic [8:0] h, input logic [7:0] s, input logic [7:0] v,
                           input logic [7:0] w, input logic [7:0] a);
    hsvrgb_pkg::hsv_word_t px;
    px.hue        = h;
    px.saturation = s;
    px.brightness = v;
    px.white_in   = w;
    px.alpha_in   = a;
    pixel_q.push_back(px);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      n_err++;
    end
  endtask

  // input side
  always @(posedge clk) begin
    if (rst) begin
      hsv_valid <= 1'b0;
      tx_gap    <= 0;
      tx_quiet  <= 0;
    end else begin
      if (hsv_valid && !hsv_stall) begin
        rgb_due_q.push_back(convert_pixel(hsv));
        if (hsv.hue >= FULL_TURN) n_wrapped++;
      end
      if (!hsv_valid || !hsv_stall) begin
        if (tx_gap != 0) begin
          hsv_valid <= 1'b0;
          tx_gap    <= tx_gap - 1;
        end else if (pixel_q.size() != 0) begin
          hsv       <= pixel_q.pop_front();
          hsv_valid <= 1'b1;
          if (tx_quiet != 0) begin
            tx_gap   <= 0;
            tx_quiet <= tx_quiet - 1;
          end else begin
            tx_gap <= rand_gap();
            if ($urandom_range(99) < 4) tx_quiet <= $urandom_range(20, 60);
          end
        end else begin
          hsv_valid <= 1'b0;
        end
      end
    end
  end

  // output backpressure
  always @(posedge clk) begin
    if (rst) begin
      rgb_stall <= 1'b0;
      rx_hold   <= 0;
      rx_quiet  <= 0;
    end else if (rx_hold != 0) begin
      rgb_stall <= 1'b1;
      rx_hold   <= rx_hold - 1;
    end else if (rx_quiet != 0) begin
      rgb_stall <= 1'b0;
      rx_quiet  <= rx_quiet - 1;
    end else begin
      rgb_stall <= 1'b0;
      rx_hold   <= rand_gap();
      if ($urandom_range(99) < 4) rx_quiet <= $urandom_range(20, 80);
    end
  end

  // result check
  always @(posedge clk) begin
    if (!rst && rgb_valid && !rgb_stall) begin
      if (rgb_due_q.size() == 0) begin
        $error("unexpected rgb word: %h", rgb);
        n_err++;
      end else begin
        want = rgb_due_q.pop_front();
        check_field("red", want.red, rgb.red);
        check_field("green", want.green, rgb.green);
        check_field("blue", want.blue, rgb.blue);
        check_field("white_out", want.white_out, rgb.white_out);
        check_field("alpha_out", want.alpha_out, rgb.alpha_out);
        n_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (hsv_valid && !hsv_stall) || (rgb_valid && !rgb_stall)) begin
      idle_clks <= 0;
    end else if (idle_clks >= IDLE_LIMIT) begin
      $display("timeout: %0d words still due", rgb_due_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_clks <= idle_clks + 1;
    end
  end

  initial begin
    // sector edges, hue wrap, extremes of saturation and brightness
    add_pixel(9'd0,   8'd255, 8'd255, 8'd0,   8'd255);
    add_pixel(9'd59,  8'd255, 8'd255, 8'd255, 8'd0);
    add_pixel(9'd60,  8'd255, 8'd255, 8'hAA,  8'h55);
    add_pixel(9'd119, 8'd200, 8'd180, 8'h55,  8'hAA);
    add_pixel(9'd120, 8'd255, 8'd255, 8'd1,   8'd128);
    add_pixel(9'd179, 8'd128, 8'd255, 8'd128, 8'd1);
    add_pixel(9'd180, 8'd255, 8'd200, 8'd0,   8'd0);
    add_pixel(9'd239, 8'd77,  8'd99,  8'd255, 8'd255);
    add_pixel(9'd240, 8'd255, 8'd255, 8'd17,  8'd34);
    add_pixel(9'd299, 8'd255, 8'd128, 8'd34,  8'd17);
    add_pixel(9'd300, 8'd255, 8'd255, 8'd200, 8'd100);
    add_pixel(9'd359, 8'd255, 8'd255, 8'd100, 8'd200);
    add_pixel(9'd360, 8'd255, 8'd255, 8'd3,   8'd4);
    add_pixel(9'd419, 8'd200, 8'd150, 8'd5,   8'd6);
    add_pixel(9'd511, 8'd255, 8'd255, 8'd7,   8'd8);
    add_pixel(9'd256, 8'd255, 8'd255, 8'd9,   8'd10);
    add_pixel(9'd90,  8'd0,   8'd255, 8'd11,  8'd12);
    add_pixel(9'd200, 8'd0,   8'd123, 8'd13,  8'd14);
    add_pixel(9'd30,  8'd255, 8'd0,   8'd15,  8'd16);
    add_pixel(9'd330, 8'd0,   8'd0,   8'd255, 8'd255);
    add_pixel(9'd30,  8'd1,   8'd1,   8'd0,   8'd0);
    add_pixel(9'd150, 8'd1,   8'd255, 8'd0,   8'd0);

    for (int i = 0; i < RAND_PIXELS; i++) begin
      add_pixel(rand_hue(), rand_level(), rand_level(),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pixel_q.size() != 0 || hsv_valid) @(posedge clk);
    while (rgb_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CLKS) @(posedge clk);

    $display("%0d pixels converted and checked, %0d of them with hue past 359,",
             n_checked, n_wrapped);
    $display("with random gaps on the input and random stalls on the output");
    if (n_err == 0 && rgb_due_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: hsv_to_rgbwa_pixel.f
hdl/hsvrgb_pkg.sv
hdl/hsvrgb_front.sv
hdl/hsvrgb_div.sv
hdl/hsvrgb_out.sv
hdl/hsv_to_rgbwa_pixel.sv
tb/tb_hsv_to_rgbwa_pixel.sv
